>>> sv/bbc_pkg.sv
// types, codes and character classification shared by the bracket checker
`timescale 1ns / 1ps

package bbc_pkg;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_OPEN     = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    localparam logic [7:0] CH_TERM       = 8'h00;
    localparam logic [7:0] CH_OPEN_ROUND = 8'h28;
    localparam logic [7:0] CH_SHUT_ROUND = 8'h29;
    localparam logic [7:0] CH_OPEN_CURLY = 8'h7b;
    localparam logic [7:0] CH_SHUT_CURLY = 8'h7d;
    localparam logic [7:0] CH_OPEN_SQR   = 8'h5b;
    localparam logic [7:0] CH_SHUT_SQR   = 8'h5d;

    function automatic t_kind open_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_OPEN_ROUND: k = KIND_ROUND;
            CH_OPEN_CURLY: k = KIND_CURLY;
            CH_OPEN_SQR:   k = KIND_SQUARE;
            default:       k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind close_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_SHUT_ROUND: k = KIND_ROUND;
            CH_SHUT_CURLY: k = KIND_CURLY;
            CH_SHUT_SQR:   k = KIND_SQUARE;
            default:       k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> sv/bracket_balance_checker.sv
// top level of the bracket balance checker: control, stack cell row, result register
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+----------------------
//  input    | i_valid | o_ready | i_ch
//  result   | o_valid | i_ready | o_balanced, o_status
//
//  one byte per cycle while o_ready is high; only cell 0 (the stack top) is compared on a closing bracket
//  result appears the cycle after the terminator transfer, held in an output register
//  input is taken whenever that register is empty or being drained in the same cycle
//  synchronous active-low reset clears depth, failure code and result valid
//  stack cells need no clearing pass, depth bounds every read
`timescale 1ns / 1ps

module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_balanced,
    output logic [2:0] o_status
);
    import bbc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    logic [DW-1:0] r_depth, n_depth;
    t_status       r_fail, n_fail;
    logic          r_out_valid, n_out_valid;
    logic          r_balanced, n_balanced;
    t_status       r_status, n_status;

    t_kind  w_kind [STACK_DEPTH];
    t_shift w_shift;
    t_kind  w_open, w_close;
    logic   w_xfer, w_term, w_live;
    t_status w_end_status;

    assign o_ready = !r_out_valid || i_ready;
    assign w_xfer  = i_valid && o_ready;
    assign w_term  = (i_ch == CH_TERM);
    assign w_open  = open_kind(i_ch);
    assign w_close = close_kind(i_ch);
    assign w_live  = w_xfer && !w_term && (r_fail == ST_OK);

    assign w_shift.push = w_live && (w_open != KIND_NONE) && (r_depth != FULL);
    assign w_shift.pop  = w_live && (w_close != KIND_NONE) && (r_depth != '0);

    assign w_end_status = (r_fail != ST_OK) ? r_fail :
                          ((r_depth != '0) ? ST_OPEN : ST_OK);

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_kind w_above, w_below;
            if (g == 0) begin : g_top
                assign w_above = w_open;
            end else begin : g_mid
                assign w_above = w_kind[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_bot
                assign w_below = KIND_ROUND;
            end else begin : g_inner
                assign w_below = w_kind[g+1];
            end
            bbc_cell u_cell (
                .i_clk        (i_clk),
                .i_shift      (w_shift),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_kind       (w_kind[g])
            );
        end
    endgenerate

    always_comb begin
        n_depth     = r_depth;
        n_fail      = r_fail;
        n_out_valid = r_out_valid && !i_ready;
        n_balanced  = r_balanced;
        n_status    = r_status;
        if (w_xfer && w_term) begin
            n_depth     = '0;
            n_fail      = ST_OK;
            n_out_valid = 1'b1;
            n_balanced  = (w_end_status == ST_OK);
            n_status    = w_end_status;
        end else if (w_live) begin
            if (w_open != KIND_NONE) begin
                if (r_depth == FULL) begin
                    n_fail = ST_OVERFLOW;
                end else begin
                    n_depth = r_depth + 1'b1;
                end
            end else if (w_close != KIND_NONE) begin
                if (r_depth == '0) begin
                    n_fail = ST_EMPTY;
                end else begin
                    n_depth = r_depth - 1'b1;
                    if (w_kind[0] != w_close) begin
                        n_fail = ST_MISMATCH;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_fail      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_fail      <= n_fail;
            r_out_valid <= n_out_valid;
        end
        r_balanced <= n_balanced;
        r_status   <= n_status;
    end

    assign o_valid    = r_out_valid;
    assign o_balanced = r_balanced;
    assign o_status   = r_status;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= FULL)
        else $error("stack depth beyond capacity");

    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && w_term) |=> (o_valid && r_depth == '0 && r_fail == ST_OK))
        else $error("terminator transfer did not produce a result and clear");

    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_balanced == (o_status == ST_OK)))
        else $error("balanced flag disagrees with status");

    a_frozen_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != ST_OK) |-> (!w_shift.push && !w_shift.pop))
        else $error("stack moved after a failure");

    a_no_shift_without_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_xfer |=> $stable(r_depth))
        else $error("depth changed with no transfer");

endmodule

>>> sv/bbc_cell.sv
// one stack cell: holds a bracket kind, shifts down on push and up on pop
`timescale 1ns / 1ps

module bbc_cell (
    input  logic           i_clk,
    input  bbc_pkg::t_shift i_shift,
    input  bbc_pkg::t_kind  i_from_above,
    input  bbc_pkg::t_kind  i_from_below,
    output bbc_pkg::t_kind  o_kind
);
    import bbc_pkg::*;

    t_kind r_kind;
    t_kind n_kind;

    always_comb begin
        n_kind = r_kind;
        if (i_shift.push) begin
            n_kind = i_from_above;
        end else if (i_shift.pop) begin
            n_kind = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the bracket balance checker: directed table, random strings
`timescale 1ns / 1ps

module tb;
    import bbc_pkg::*;

    localparam int DEPTH      = 64;
    localparam int RAND_ITEMS = 1380;
    localparam int LIMIT      = 400000;
    localparam int N_ROWS     = 29;

    typedef struct packed {
        logic    balanced;
        t_status status;
    } t_verdict;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] reps;
        logic       typed;
        logic       bal;
        t_status    st;
    } t_row;

    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{CH_TERM,       8'd1,  1'b1, 1'b1, ST_OK},
        '{CH_OPEN_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_SHUT_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_OPEN_CURLY, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_SHUT_CURLY, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_OPEN_SQR,   8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_SHUT_SQR,   8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b1, ST_OK},
        '{CH_OPEN_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_SHUT_SQR,   8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b0, ST_MISMATCH},
        '{CH_SHUT_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_OPEN_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b0, ST_EMPTY},
        '{CH_OPEN_SQR,   8'd1,  1'b0, 1'b0, ST_OK},
        '{8'h61,         8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b0, ST_OPEN},
        '{8'hff,         8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_OPEN_CURLY, 8'd1,  1'b0, 1'b0, ST_OK},
        '{8'h01,         8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_SHUT_CURLY, 8'd1,  1'b0, 1'b0, ST_OK},
        '{8'h80,         8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_OPEN_ROUND, 8'd65, 1'b0, 1'b0, ST_OK},
        '{CH_SHUT_ROUND, 8'd1,  1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b0, ST_OVERFLOW},
        '{CH_OPEN_SQR,   8'd64, 1'b0, 1'b0, ST_OK},
        '{CH_SHUT_SQR,   8'd64, 1'b0, 1'b0, ST_OK},
        '{CH_TERM,       8'd1,  1'b1, 1'b1, ST_OK}
    };

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_ch    = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_balanced;
    logic [2:0] o_status;

    t_verdict   verdict_q [$];
    logic [7:0] text_q [$];

    t_kind      mdl_stack [DEPTH];
    int         mdl_depth = 0;
    t_status    mdl_fail  = ST_OK;

    int send_idle = 16;
    int recv_idle = 72;
    int errors    = 0;
    int cycles    = 0;
    int n_bytes   = 0;
    int n_strings = 0;
    int n_checked = 0;
    int st_seen [5] = '{0, 0, 0, 0, 0};

    bracket_balance_checker #(.STACK_DEPTH(DEPTH)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_balanced (o_balanced),
        .o_status   (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, verdict_q.size());
            $display("bracket_balance_checker regression: fail");
            $finish;
        end
    end

    function automatic t_kind kind_of(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_OPEN_ROUND, CH_SHUT_ROUND: k = KIND_ROUND;
            CH_OPEN_CURLY, CH_SHUT_CURLY: k = KIND_CURLY;
            CH_OPEN_SQR, CH_SHUT_SQR:     k = KIND_SQUARE;
            default:                      k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] open_char(input t_kind k);
        logic [7:0] c;
        case (k)
            KIND_ROUND: c = CH_OPEN_ROUND;
            KIND_CURLY: c = CH_OPEN_CURLY;
            default:    c = CH_OPEN_SQR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] shut_char(input t_kind k);
        logic [7:0] c;
        case (k)
            KIND_ROUND: c = CH_SHUT_ROUND;
            KIND_CURLY: c = CH_SHUT_CURLY;
            default:    c = CH_SHUT_SQR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] any_bracket();
        t_kind k;
        k = t_kind'($urandom_range(0, 2));
        return $urandom_range(0, 1) ? open_char(k) : shut_char(k);
    endfunction

    task automatic track_brackets(input logic [7:0] c, output bit done, output t_verdict v);
        t_status s;
        done = 1'b0;
        v = '{1'b0, ST_OK};
        if (c == CH_TERM) begin
            s = mdl_fail;
            if (s == ST_OK && mdl_depth != 0)
                s = ST_OPEN;
            v.balanced = (s == ST_OK);
            v.status = s;
            mdl_depth = 0;
            mdl_fail = ST_OK;
            done = 1'b1;
        end else if (mdl_fail == ST_OK) begin
            case (c)
                CH_OPEN_ROUND, CH_OPEN_CURLY, CH_OPEN_SQR: begin
                    if (mdl_depth >= DEPTH) begin
                        mdl_fail = ST_OVERFLOW;
                    end else begin
                        mdl_stack[mdl_depth] = kind_of(c);
                        mdl_depth++;
                    end
                end
                CH_SHUT_ROUND, CH_SHUT_CURLY, CH_SHUT_SQR: begin
                    if (mdl_depth == 0) begin
                        mdl_fail = ST_EMPTY;
                    end else begin
                        mdl_depth--;
                        if (mdl_stack[mdl_depth] != kind_of(c))
                            mdl_fail = ST_MISMATCH;
                    end
                end
                default: ;
            endcase
        end
    endtask

    // called at a rising edge, returns at the edge of the transfer
    task automatic send_byte(input logic [7:0] c, input bit typed, input logic bal,
                             input t_status st);
        int gap;
        bit done;
        t_verdict v;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        @(negedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        n_bytes++;
        track_brackets(c, done, v);
        if (done) begin
            if (typed)
                v = '{bal, st};
            verdict_q.push_back(v);
            n_strings++;
        end
    endtask

    task automatic make_string();
        int mode;
        int len;
        int pos;
        t_kind k;
        t_kind open_q [$];
        text_q.delete();
        mode = $urandom_range(0, 9);
        case (mode)
            8: begin
                len = $urandom_range(0, 20);
                repeat (len) begin
                    if ($urandom_range(0, 2) == 0)
                        text_q.push_back(any_bracket());
                    else
                        text_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            9: begin
                len = $urandom_range(56, 72);
                repeat (len) begin
                    k = t_kind'($urandom_range(0, 2));
                    open_q.push_back(k);
                    text_q.push_back(open_char(k));
                end
                while (open_q.size() > 0)
                    text_q.push_back(shut_char(open_q.pop_back()));
            end
            default: begin
                len = $urandom_range(0, 24);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_q.push_back(8'($urandom_range(1, 255)));
                    end else if (open_q.size() == 0 || $urandom_range(0, 1) == 1) begin
                        k = t_kind'($urandom_range(0, 2));
                        open_q.push_back(k);
                        text_q.push_back(open_char(k));
                    end else begin
                        text_q.push_back(shut_char(open_q.pop_back()));
                    end
                end
                while (open_q.size() > 0)
                    text_q.push_back(shut_char(open_q.pop_back()));
                if (mode == 6 && text_q.size() > 0) begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    text_q[pos] = any_bracket();
                end
                if (mode == 7 && text_q.size() > 0) begin
                    len = $urandom_range(1, text_q.size());
                    repeat (len) void'(text_q.pop_back());
                end
            end
        endcase
    endtask

    // result transfer happens at the next rising edge; values are stable here
    always @(negedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no string pending, balanced %0d status %0d",
                         $time, o_balanced, o_status);
                errors++;
            end else begin
                v = verdict_q.pop_front();
                n_checked++;
                st_seen[v.status]++;
                if (o_balanced !== v.balanced) begin
                    $display("%0t: balanced expected %0d got %0d",
                             $time, v.balanced, o_balanced);
                    errors++;
                end
                if (o_status !== v.status) begin
                    $display("%0t: status expected %0d got %0d", $time, v.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_ROWS; r++) begin
            repeat (DIR_ROWS[r].reps)
                send_byte(DIR_ROWS[r].ch, DIR_ROWS[r].typed, DIR_ROWS[r].bal, DIR_ROWS[r].st);
        end
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 16;
                    recv_idle = 72;
                end
                1: begin
                    send_idle = 72;
                    recv_idle = 16;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            target = n_bytes + RAND_ITEMS / 3;
            while (n_bytes < target) begin
                make_string();
                foreach (text_q[j])
                    send_byte(text_q[j], 1'b0, 1'b0, ST_OK);
                send_byte(CH_TERM, 1'b0, 1'b0, ST_OK);
            end
        end
        i_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("%0d byte transfers in %0d strings, %0d verdicts checked",
                 n_bytes, n_strings, n_checked);
        $display("verdicts: ok %0d, mismatch %0d, close on empty %0d, left open %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
        $display("verdicts: overflow %0d", st_seen[4]);
        if (errors == 0)
            $display("bracket_balance_checker regression: pass");
        else
            $display("bracket_balance_checker regression: fail");
        $finish;
    end

endmodule
